[src/b64se_pkg.sv]
// Package for the base64 stream encoder.
// Holds the group descriptor type, queue sizing and the alphabet lookup.
`default_nettype none
package b64se_pkg;

  localparam int unsigned QDepth = 2;
  localparam int unsigned QAw    = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned QCw    = $clog2(QDepth + 1);

  localparam logic [6:0] PadChar = 7'd61;

  localparam logic [1:0] NBytesOne   = 2'd1;
  localparam logic [1:0] NBytesTwo   = 2'd2;
  localparam logic [1:0] NBytesThree = 2'd3;

  localparam logic [1:0] SlotFirst = 2'd0;
  localparam logic [1:0] SlotSecnd = 2'd1;
  localparam logic [1:0] SlotThird = 2'd2;
  localparam logic [1:0] SlotFinal = 2'd3;

  typedef struct packed {
    logic [23:0] bits;
    logic [1:0]  nbytes;
    logic        last;
  } group_t;

  function automatic logic [6:0] b64_char(input logic [5:0] sx);
    logic [6:0] v;
    v = {1'b0, sx};
    if (sx < 6'd26) begin
      b64_char = v + 7'd65;
    end else if (sx < 6'd52) begin
      b64_char = v + 7'd71;
    end else if (sx < 6'd62) begin
      b64_char = v - 7'd4;
    end else if (sx == 6'd62) begin
      b64_char = 7'd43;
    end else begin
      b64_char = 7'd47;
    end
  endfunction

endpackage
`default_nettype wire

[src/base64_stream_encoder_top.sv]
// Base64 stream encoder top level.
// Depends on b64se_pkg, b64se_front, b64se_queue, b64se_back.
//
// Encodes a byte stream to base64 (standard alphabet, '=' padding). One byte
// is taken per cycle while full is low; full is high while the group queue
// holds two groups. A group of three bytes, or the partial group closed by
// last_byte_i, yields four characters that leave one per cycle while pop is
// held. The character serializer sets the sustained rate: every group, full
// or partial, is sent as four characters. The first character of a group is
// ready once the group has passed the group queue and been loaded into the
// serializer's group register. A two-entry group queue lets the input keep
// running while characters wait. The final character of each message has
// last_char_o set.
`default_nettype none
module base64_stream_encoder_top (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] byte_value_i,
  input  wire logic       last_byte_i,
  output logic            empty,
  input  wire logic       pop,
  output logic [6:0]      char_code_o,
  output logic            last_char_o
);
  import b64se_pkg::*;

  logic   accept;
  logic   grp_push;
  group_t grp_w;
  logic   q_full, q_empty, q_pop;
  group_t q_data;

  assign full   = q_full;
  assign accept = push && !q_full;

  b64se_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .byte_value_i (byte_value_i),
    .last_byte_i  (last_byte_i),
    .grp_push_o   (grp_push),
    .grp_o        (grp_w)
  );

  b64se_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (grp_push),
    .wdata_i (grp_w),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .rdata_o (q_data)
  );

  b64se_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_data_i    (q_data),
    .q_pop_o     (q_pop),
    .pop_i       (pop),
    .empty_o     (empty),
    .char_code_o (char_code_o),
    .last_char_o (last_char_o)
  );

endmodule
`default_nettype wire

[src/b64se_front.sv]
// Front end: accepts bytes, holds up to two pending bytes, emits groups.
// Depends on b64se_pkg.
`default_nettype none
module b64se_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            accept_i,
  input  wire logic [7:0]      byte_value_i,
  input  wire logic            last_byte_i,
  output logic                 grp_push_o,
  output b64se_pkg::group_t    grp_o
);
  import b64se_pkg::*;

  logic [15:0] pend_d, pend_q;
  logic [1:0]  cnt_d, cnt_q;

  always_comb begin
    pend_d     = pend_q;
    cnt_d      = cnt_q;
    grp_push_o = 1'b0;
    grp_o.bits   = {pend_q, byte_value_i};
    grp_o.nbytes = NBytesThree;
    grp_o.last   = last_byte_i;
    if (accept_i) begin
      if (cnt_q >= 2'd2) begin
        grp_push_o = 1'b1;
        pend_d     = '0;
        cnt_d      = '0;
      end else if (last_byte_i) begin
        grp_push_o = 1'b1;
        pend_d     = '0;
        cnt_d      = '0;
        if (cnt_q == 2'd0) begin
          grp_o.bits   = {byte_value_i, 16'd0};
          grp_o.nbytes = NBytesOne;
        end else begin
          grp_o.bits   = {pend_q[15:8], byte_value_i, 8'd0};
          grp_o.nbytes = NBytesTwo;
        end
      end else begin
        if (cnt_q == 2'd0) begin
          pend_d = {byte_value_i, 8'd0};
        end else begin
          pend_d = {pend_q[15:8], byte_value_i};
        end
        cnt_d = cnt_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      cnt_q  <= '0;
    end else begin
      pend_q <= pend_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule
`default_nettype wire

[src/b64se_queue.sv]
// Short group queue between front and back ends.
// Depends on b64se_pkg.
`default_nettype none
module b64se_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire b64se_pkg::group_t wdata_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output logic                 empty_o,
  output b64se_pkg::group_t    rdata_o
);
  import b64se_pkg::*;

  group_t            mem_q [QDepth];
  logic [QAw-1:0]    wr_q, rd_q;
  logic [QCw-1:0]    cnt_q;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == QCw'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == QAw'(QDepth - 1)) ? '0 : wr_q + QAw'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == QAw'(QDepth - 1)) ? '0 : rd_q + QAw'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + QCw'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - QCw'(1);
      end
    end
  end

endmodule
`default_nettype wire

[src/b64se_back.sv]
// Back end: serializes one group into four characters, one per pop.
// Depends on b64se_pkg.
`default_nettype none
module b64se_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              q_empty_i,
  input  wire b64se_pkg::group_t q_data_i,
  output logic                   q_pop_o,
  input  wire logic              pop_i,
  output logic                   empty_o,
  output logic [6:0]             char_code_o,
  output logic                   last_char_o
);
  import b64se_pkg::*;

  group_t     cur_q;
  logic       busy_q;
  logic [1:0] idx_q;
  logic       done;
  logic [5:0] sx;

  assign empty_o = !busy_q;
  assign done    = busy_q && pop_i && (idx_q == SlotFinal);
  assign q_pop_o = (!busy_q || done) && !q_empty_i;

  always_comb begin
    case (idx_q)
      SlotFirst: sx = cur_q.bits[23:18];
      SlotSecnd: sx = cur_q.bits[17:12];
      SlotThird: sx = cur_q.bits[11:6];
      default:   sx = cur_q.bits[5:0];
    endcase
    char_code_o = b64_char(sx);
    if ((idx_q == SlotThird) && (cur_q.nbytes < NBytesTwo)) begin
      char_code_o = PadChar;
    end
    if ((idx_q == SlotFinal) && (cur_q.nbytes < NBytesThree)) begin
      char_code_o = PadChar;
    end
    last_char_o = (idx_q == SlotFinal) && cur_q.last;
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cur_q <= q_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= SlotFirst;
    end else begin
      if (q_pop_o) begin
        busy_q <= 1'b1;
        idx_q  <= SlotFirst;
      end else if (done) begin
        busy_q <= 1'b0;
        idx_q  <= SlotFirst;
      end else if (busy_q && pop_i) begin
        idx_q <= idx_q + 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

[tb/sv/tb_top.sv]
// Self-checking testbench for base64_stream_encoder_top.
// Feeds bytes through the push/full side and checks every character popped against an
// internal encoder model; depends on b64se_pkg and the encoder RTL.
`timescale 1ns / 1ps
module tb_top;
  import b64se_pkg::*;

  localparam int unsigned IdleLimit = 2000;
  localparam int unsigned TailCycles = 12;
  localparam bit [511:0] Alphabet =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  typedef struct packed {
    logic [6:0] code;
    logic       last;
  } enc_char_t;

  logic       clk_i;
  logic       rst_ni;
  logic       push;
  logic       full;
  logic [7:0] byte_value_i;
  logic       last_byte_i;
  logic       empty;
  logic       pop;
  logic [6:0] char_code_o;
  logic       last_char_o;

  enc_char_t   expected_chars[$];
  logic [15:0] held_bytes;
  logic [1:0]  held_count;
  int unsigned mismatches;
  int unsigned idle_cycles = 0;
  int unsigned rx_hold;
  bit          tx_stall_en;
  bit          rx_stall_en;

  base64_stream_encoder_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .byte_value_i(byte_value_i),
    .last_byte_i (last_byte_i),
    .empty       (empty),
    .pop         (pop),
    .char_code_o (char_code_o),
    .last_char_o (last_char_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [6:0] sextet_char(input logic [5:0] sx);
    return Alphabet[8 * (63 - int'(sx)) +: 7];
  endfunction

  task automatic add_char(input logic [6:0] code, input logic last);
    enc_char_t c;
    c.code = code;
    c.last = last;
    expected_chars.insert(expected_chars.size(), c);
  endtask

  task automatic encode_byte(input logic [7:0] b, input logic lst);
    logic [23:0] grp;
    int          nb;
    if (held_count >= 2'd2) begin
      grp = {held_bytes, b};
      nb = 3;
    end else if (lst) begin
      if (held_count == 2'd0) begin
        grp = {b, 16'h0000};
        nb = 1;
      end else begin
        grp = {held_bytes[15:8], b, 8'h00};
        nb = 2;
      end
    end else begin
      if (held_count == 2'd0) begin
        held_bytes = {b, 8'h00};
      end else begin
        held_bytes[7:0] = b;
      end
      held_count = held_count + 2'd1;
      return;
    end
    add_char(sextet_char(grp[23:18]), 1'b0);
    add_char(sextet_char(grp[17:12]), 1'b0);
    add_char((nb >= 2) ? sextet_char(grp[11:6]) : PadChar, 1'b0);
    add_char((nb >= 3) ? sextet_char(grp[5:0]) : PadChar, lst);
    held_bytes = '0;
    held_count = '0;
  endtask

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%s", msg);
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic lst);
    int gap;
    @(negedge clk_i);
    push <= 1'b1;
    byte_value_i <= b;
    last_byte_i <= lst;
    do @(posedge clk_i); while (full);
    encode_byte(b, lst);
    if (tx_stall_en && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 7);
      @(negedge clk_i);
      push <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_message(input int len);
    for (int i = 0; i < len; i++) begin
      send_byte(rand_byte(), i == len - 1);
    end
  endtask

  task automatic wait_drain();
    @(negedge clk_i);
    push <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk_i);
  endtask

  // Receiver: holds pop low while rx_hold counts down, else random stall bursts when enabled
  initial begin
    int burst;
    burst = 0;
    pop = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (rx_hold > 0) begin
        rx_hold--;
        pop <= 1'b0;
      end else if (burst > 0) begin
        burst--;
        pop <= 1'b0;
      end else if (rx_stall_en && $urandom_range(0, 7) == 0) begin
        burst = $urandom_range(1, 7) - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : check_chars
    enc_char_t want;
    if (rst_ni && pop && !empty) begin
      if (expected_chars.size() == 0) begin
        note_mismatch($sformatf("unexpected char: code=%0d last=%0b",
                                char_code_o, last_char_o));
      end else begin
        want = expected_chars.pop_front();
        if (char_code_o !== want.code) begin
          note_mismatch($sformatf("char_code mismatch: exp=%0d act=%0d",
                                  want.code, char_code_o));
        end
        if (last_char_o !== want.last) begin
          note_mismatch($sformatf("last_char mismatch: exp=%0b act=%0b",
                                  want.last, last_char_o));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    while (idle_cycles < IdleLimit) @(posedge clk_i);
    $display("DONE: errors detected");
    $finish;
  end

  task automatic test_directed();
    tx_stall_en = 1'b0;
    rx_stall_en = 1'b0;
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hFB, 1'b0);
    send_byte(8'hEF, 1'b0);
    send_byte(8'hBE, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h4D, 1'b0);
    send_byte(8'h61, 1'b0);
    send_byte(8'h6E, 1'b0);
    send_byte(8'h01, 1'b1);
    send_byte(8'h80, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'hAA, 1'b1);
    send_byte(8'h55, 1'b0);
    send_byte(8'hC3, 1'b1);
    wait_drain();
  endtask

  task automatic test_random(input int items);
    int sent;
    int len;
    sent = 0;
    tx_stall_en = 1'b1;
    rx_stall_en = 1'b1;
    while (sent < items) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 9);
      send_message(len);
      sent += len;
    end
  endtask

  task automatic test_backpressure();
    tx_stall_en = 1'b0;
    wait_drain();
    rx_hold = 80;
    send_message(40);
    wait_drain();
  endtask

  task automatic test_drain_pause();
    tx_stall_en = 1'b1;
    send_message(5);
    wait_drain();
    repeat ($urandom_range(1, 7)) @(negedge clk_i);
    send_message(4);
  endtask

  task automatic test_no_idle();
    tx_stall_en = 1'b0;
    rx_stall_en = 1'b0;
    send_message(7);
    send_message(11);
    send_message(12);
  endtask

  initial begin
    rst_ni = 1'b0;
    push = 1'b0;
    byte_value_i = '0;
    last_byte_i = 1'b0;
    held_bytes = '0;
    held_count = '0;
    mismatches = 0;
    rx_hold = 0;
    tx_stall_en = 1'b0;
    rx_stall_en = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_random(170);
    test_backpressure();
    test_drain_pause();
    test_no_idle();
    wait_drain();
    repeat (TailCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[files.f]
src/b64se_pkg.sv
src/b64se_front.sv
src/b64se_queue.sv
src/b64se_back.sv
src/base64_stream_encoder_top.sv
tb/sv/tb_top.sv
